// File: src/multi_slot_oneshot_timer_defines.svh
// Assertion macros for the multi-slot one-shot timer.
`ifndef MULTI_SLOT_ONESHOT_TIMER_DEFINES_SVH
`define MULTI_SLOT_ONESHOT_TIMER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MSOT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define MSOT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSOT_ASSERT_NOW(lbl, ante, cons, msg)
`define MSOT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/msot_pkg.sv
package msot_pkg;

  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_QUANTA_PER_MS = 1'b0;
  localparam logic [15:0] QPM_RESET = 16'd1;
  localparam logic [15:0] SAT16 = 16'hFFFF;

  typedef enum logic [1:0] {
    EV_SCHED  = 2'd0,
    EV_REJECT = 2'd1,
    EV_FIRED  = 2'd2,
    EV_NONE   = 2'd3
  } msot_ev_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic reject;
    logic srch_step;
    logic sched;
    logic tick_idle;
    logic tick_adv;
    logic scan_init;
    logic scan_rd;
    logic finish;
  } msot_cmd_t;

  typedef struct packed {
    logic full;
    logic slot_free;
    logic counting;
    logic expire;
    logic scan_last;
  } msot_stat_t;

endpackage

// File: src/msot_regs.sv
module msot_regs
  import msot_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [15:0]       qpm
);

  logic hit;

  assign hit    = (paddr[ADDR_W-1:2] == REG_QUANTA_PER_MS);
  assign pready = 1'b1;
  assign prdata = hit ? {16'd0, qpm} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      qpm <= QPM_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      qpm <= pwdata[15:0];
    end
  end

endmodule

// File: src/msot_ctrl.sv
module msot_ctrl
  import msot_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       mode,
  input  msot_stat_t stat,
  output msot_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SRCH,
    S_TICK,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = mode ? S_TICK : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (stat.full) begin
          cmd.reject = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        if (stat.slot_free) begin
          cmd.sched  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_TICK: begin
        if (!stat.counting) begin
          cmd.tick_idle = 1'b1;
          state_next    = S_IDLE;
        end else if (!stat.expire) begin
          cmd.tick_adv  = 1'b1;
          cmd.tick_idle = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// File: src/msot_dp.sv
module msot_dp
  import msot_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  msot_cmd_t   cmd,
  output msot_stat_t  stat,
  input  logic [15:0] qpm,
  input  logic [15:0] delay_ms,
  input  logic [7:0]  action_id,
  output logic        res_valid,
  output logic [1:0]  event_res,
  output logic [7:0]  fired_id,
  output logic [3:0]  slot_used,
  output logic        last
);

  localparam int SW  = $clog2(SLOTS);
  localparam int OCW = $clog2(SLOTS + 1);

  logic [7:0]     mem_id  [SLOTS];
  logic [32:0]    mem_rem [SLOTS];

  logic [SLOTS-1:0] busy_v;
  logic [15:0]    delay_r;
  logic [7:0]     id_r;
  logic [31:0]    quanta;
  logic [15:0]    count_now;
  logic [15:0]    reload;
  logic           counting;
  logic [SW-1:0]  next_slot;
  logic [OCW-1:0] occ;
  logic [SW-1:0]  ptr;
  logic [SW-1:0]  idx;
  logic           p_vld;
  logic [SW-1:0]  p_idx;
  logic [7:0]     rd_id;
  logic [32:0]    rd_rem;
  logic           pend_vld;
  logic [7:0]     pend_id;
  logic [SW-1:0]  pend_idx;
  logic           any_left;
  logic [32:0]    minrem;

  logic [SW-1:0]  ptr_inc;
  logic [15:0]    count_inc;
  logic [32:0]    rem_new;
  logic [32:0]    sched_rem;
  logic [15:0]    gap;
  logic           shorten;
  logic           proc_fire;
  logic           proc_keep;
  logic           new_min;

  logic           em_vld;
  msot_ev_t       em_ev;
  logic [7:0]     em_id;
  logic [3:0]     em_slot;
  logic           em_last;

  assign ptr_inc   = (ptr == SW'(SLOTS - 1)) ? '0 : ptr + 1'b1;
  assign count_inc = count_now + 16'd1;
  assign rem_new   = rd_rem - {17'd0, reload};
  assign sched_rem = counting ? {1'b0, quanta} + {17'd0, count_now} : {1'b0, quanta};
  assign gap       = reload - count_now;
  assign shorten   = (reload > count_now) && ({16'd0, gap} > quanta);
  assign proc_fire = p_vld && busy_v[p_idx] && (rd_rem <= {17'd0, reload});
  assign proc_keep = p_vld && busy_v[p_idx] && !(rd_rem <= {17'd0, reload});
  assign new_min   = !any_left || (rem_new < minrem);

  assign stat.full      = (occ == OCW'(SLOTS));
  assign stat.slot_free = !busy_v[ptr];
  assign stat.counting  = counting;
  assign stat.expire    = !(count_inc < reload);
  assign stat.scan_last = (idx == SW'(SLOTS - 1));

  always_comb begin
    em_vld  = 1'b0;
    em_ev   = EV_NONE;
    em_id   = 8'd0;
    em_slot = 4'd0;
    em_last = 1'b1;
    if (cmd.reject) begin
      em_vld = 1'b1;
      em_ev  = EV_REJECT;
    end else if (cmd.sched) begin
      em_vld  = 1'b1;
      em_ev   = EV_SCHED;
      em_slot = 4'(ptr);
    end else if (cmd.tick_idle) begin
      em_vld = 1'b1;
    end else if (proc_fire && pend_vld) begin
      em_vld  = 1'b1;
      em_ev   = EV_FIRED;
      em_id   = pend_id;
      em_slot = 4'(pend_idx);
      em_last = 1'b0;
    end else if (cmd.finish) begin
      em_vld = 1'b1;
      if (pend_vld) begin
        em_ev   = EV_FIRED;
        em_id   = pend_id;
        em_slot = 4'(pend_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_v    <= '0;
      count_now <= 16'd0;
      reload    <= 16'd0;
      counting  <= 1'b0;
      next_slot <= '0;
      occ       <= '0;
      res_valid <= 1'b0;
      p_vld     <= 1'b0;
      pend_vld  <= 1'b0;
      any_left  <= 1'b0;
    end else begin
      res_valid <= em_vld;
      p_vld     <= cmd.scan_rd;
      if (cmd.sched) begin
        busy_v[ptr] <= 1'b1;
        occ         <= occ + 1'b1;
        next_slot   <= ptr_inc;
        if (counting) begin
          if (shorten) begin
            reload <= count_now + quanta[15:0];
          end
        end else begin
          count_now <= 16'd0;
          reload    <= (quanta >= {16'd0, SAT16}) ? SAT16 : quanta[15:0];
          counting  <= 1'b1;
        end
      end
      if (cmd.tick_adv) begin
        count_now <= count_inc;
      end
      if (cmd.scan_init) begin
        pend_vld <= 1'b0;
        any_left <= 1'b0;
      end
      if (proc_fire) begin
        busy_v[p_idx] <= 1'b0;
        occ           <= occ - 1'b1;
        pend_vld      <= 1'b1;
      end
      if (proc_keep) begin
        any_left <= 1'b1;
      end
      if (cmd.finish) begin
        count_now <= 16'd0;
        if (any_left) begin
          reload <= (minrem >= {17'd0, SAT16}) ? SAT16 : minrem[15:0];
        end else begin
          counting  <= 1'b0;
          next_slot <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    event_res <= em_ev;
    fired_id  <= em_id;
    slot_used <= em_slot;
    last      <= em_last;
    p_idx     <= idx;
    if (cmd.load) begin
      delay_r <= delay_ms;
      id_r    <= action_id;
      ptr     <= next_slot;
    end
    if (cmd.srch_step) begin
      ptr <= ptr_inc;
    end
    if (cmd.mul) begin
      quanta <= 32'(delay_r) * 32'(qpm);
    end
    if (cmd.scan_init) begin
      idx <= '0;
    end else if (cmd.scan_rd) begin
      idx <= idx + 1'b1;
    end
    if (proc_fire) begin
      pend_id  <= rd_id;
      pend_idx <= p_idx;
    end
    if (proc_keep && new_min) begin
      minrem <= rem_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sched) begin
      mem_id[ptr] <= id_r;
    end
    if (cmd.scan_rd) begin
      rd_id <= mem_id[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sched) begin
      mem_rem[ptr] <= sched_rem;
    end else if (proc_keep) begin
      mem_rem[p_idx] <= rem_new;
    end
    if (cmd.scan_rd) begin
      rd_rem <= mem_rem[idx];
    end
  end

endmodule

// File: src/multi_slot_oneshot_timer.sv
// Schedule: a free slot is searched for after accept (one slot searched a cycle); reject if full.
// Expiry tick: one slot read a cycle from the table memory; fired beats in slot order, at
// most one a cycle, last beat as busy drops.
// One item at a time, next item taken once busy drops; results cannot be stalled.
// Reset: table empty, counter stopped, quanta_per_ms = 1; no clearing pass.
`include "multi_slot_oneshot_timer_defines.svh"

module multi_slot_oneshot_timer
  import msot_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              mode,
  input  logic [15:0]       delay_ms,
  input  logic [7:0]        action_id,
  output logic              res_valid,
  output logic [1:0]        event_res,
  output logic [7:0]        fired_id,
  output logic [3:0]        slot_used,
  output logic              last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  msot_cmd_t   cmd;
  msot_stat_t  stat;
  logic [15:0] qpm;

  msot_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .qpm     (qpm)
  );

  msot_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  msot_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .qpm       (qpm),
    .delay_ms  (delay_ms),
    .action_id (action_id),
    .res_valid (res_valid),
    .event_res (event_res),
    .fired_id  (fired_id),
    .slot_used (slot_used),
    .last      (last)
  );

  `MSOT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `MSOT_ASSERT_NEXT(a_accept_quiet, start && !busy, !res_valid, "beat right after accept")
  `MSOT_ASSERT_NOW(a_single_last, res_valid && (event_res != EV_FIRED), last,
                   "single beat without last")
  `MSOT_ASSERT_NOW(a_id_zero, res_valid && (event_res != EV_FIRED), fired_id == 8'd0,
                   "fired_id set on a beat that fired nothing")

endmodule
